// ===== sv/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on clk in the using scope, switched off while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on clk in the using scope that also holds while reset is asserted
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/gnd_pkg.sv =====
// ----------------------------------------------------------------------------
// gnd_pkg
// Widths, register indexes and helpers of the gather-nd address generator.
// ----------------------------------------------------------------------------
package gnd_pkg;

    localparam int IDX_W       = 16;
    localparam int NUM_IDX     = 4;
    localparam int DESC_W      = 32;
    localparam int STRIDE_W    = 32;
    localparam int COUNT_W     = 24;
    localparam int DEPTH_W     = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PROD_W      = IDX_W + STRIDE_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INDEX_DEPTH      = 3'd0,
        REG_STRIDE_0         = 3'd1,
        REG_STRIDE_1         = 3'd2,
        REG_STRIDE_2         = 3'd3,
        REG_STRIDE_3         = 3'd4,
        REG_BLOCK_LEN        = 3'd5,
        REG_TUPLES_PER_BATCH = 3'd6,
        REG_BATCH_STRIDE     = 3'd7
    } cfg_reg_t;

    // register index of the stride that belongs to lane k
    function automatic logic [CFG_INDEX_W-1:0] stride_index(input int k);
        return CFG_INDEX_W'(int'(REG_STRIDE_0) + k);
    endfunction

endpackage

// ===== sv/gnd_if.sv =====
// ----------------------------------------------------------------------------
// gnd_if
// Stream channels of the gather-nd address generator: index tuples in,
// copy descriptors out.
// ----------------------------------------------------------------------------
interface gnd_idx_if;
    logic                      valid;
    logic                      ready;
    logic [gnd_pkg::IDX_W-1:0] idx_0;
    logic [gnd_pkg::IDX_W-1:0] idx_1;
    logic [gnd_pkg::IDX_W-1:0] idx_2;
    logic [gnd_pkg::IDX_W-1:0] idx_3;

    modport source (output valid, idx_0, idx_1, idx_2, idx_3, input ready);
    modport sink   (input valid, idx_0, idx_1, idx_2, idx_3, output ready);
endinterface

interface gnd_desc_if;
    logic                       valid;
    logic                       ready;
    logic [gnd_pkg::DESC_W-1:0] src_offset;
    logic [gnd_pkg::DESC_W-1:0] dst_offset;
    logic                       batch_end;

    modport source (output valid, src_offset, dst_offset, batch_end, input ready);
    modport sink   (input valid, src_offset, dst_offset, batch_end, output ready);
endinterface

// ===== sv/gather_nd_address_generator.sv =====
// ----------------------------------------------------------------------------
// gather_nd_address_generator
// Turns index tuples into copy descriptors for an N-dimensional gather.
// ----------------------------------------------------------------------------
// Takes one index tuple per clock while the output is not stalled and returns
// one descriptor per tuple, in order, through both register stages below.
// The first register stage captures the used index components together with
// the batch base, the running destination offset and the end-of-batch flag;
// the second stage holds the descriptor. Between them each lane has one
// 16 x 32 multiply and the lane products are summed onto the base, which sets
// the clock. Offsets wrap at OFFSET_BITS and show on the 32-bit ports.
// Configuration writes are meant for idle periods and apply to the next tuple.
module gather_nd_address_generator #(
    parameter int MAX_INDEX_DEPTH = 4,
    parameter int OFFSET_BITS     = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gnd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [gnd_pkg::CFG_DATA_W-1:0]    cfg_data,
    gnd_idx_if.sink                           idx_in,
    gnd_desc_if.source                        desc_out
);

    localparam int LANES = (MAX_INDEX_DEPTH < gnd_pkg::NUM_IDX) ?
                           MAX_INDEX_DEPTH : gnd_pkg::NUM_IDX;
    localparam int OFS_W = OFFSET_BITS;

    // configuration
    logic [gnd_pkg::DEPTH_W-1:0]  depth_reg;
    logic [gnd_pkg::STRIDE_W-1:0] stride_reg [LANES];
    logic [gnd_pkg::DESC_W-1:0]   block_len_reg;
    logic [gnd_pkg::COUNT_W-1:0]  tuples_reg;
    logic [gnd_pkg::DESC_W-1:0]   batch_stride_reg;

    // running state
    logic [OFS_W-1:0]             batch_base_reg;
    logic [OFS_W-1:0]             batch_base_next;
    logic [OFS_W-1:0]             dst_reg;
    logic [OFS_W-1:0]             dst_next;
    logic [gnd_pkg::COUNT_W-1:0]  count_reg;
    logic [gnd_pkg::COUNT_W-1:0]  count_next;

    // first stage
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic [gnd_pkg::IDX_W-1:0]    s1_idx_reg [LANES];
    logic [OFS_W-1:0]             s1_base_reg;
    logic [OFS_W-1:0]             s1_dst_reg;
    logic                         s1_last_reg;

    // output stage
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [gnd_pkg::DESC_W-1:0]   out_src_reg;
    logic [gnd_pkg::DESC_W-1:0]   out_dst_reg;
    logic                         out_last_reg;

    logic                         out_adv;
    logic                         accept;
    logic [gnd_pkg::IDX_W-1:0]    idx_vec [gnd_pkg::NUM_IDX];
    logic [gnd_pkg::DEPTH_W-1:0]  used_depth;
    logic [gnd_pkg::COUNT_W-1:0]  limit;
    logic                         last;
    logic [OFS_W-1:0]             src_sum;

    assign idx_vec[0] = idx_in.idx_0;
    assign idx_vec[1] = idx_in.idx_1;
    assign idx_vec[2] = idx_in.idx_2;
    assign idx_vec[3] = idx_in.idx_3;

    assign out_adv      = !out_valid_reg || desc_out.ready;
    assign idx_in.ready = !s1_valid_reg || out_adv;
    assign accept       = idx_in.valid && idx_in.ready;

    assign used_depth = (depth_reg > gnd_pkg::DEPTH_W'(LANES)) ?
                        gnd_pkg::DEPTH_W'(LANES) : depth_reg;
    assign limit      = (tuples_reg == '0) ? gnd_pkg::COUNT_W'(1) : tuples_reg;
    assign last       = ({1'b0, count_reg} + (gnd_pkg::COUNT_W+1)'(1)) >= {1'b0, limit};

    always_comb
    begin
        batch_base_next = batch_base_reg;
        count_next      = count_reg + gnd_pkg::COUNT_W'(1);
        dst_next        = dst_reg + OFS_W'(block_len_reg);
        if (last)
        begin
            batch_base_next = batch_base_reg + OFS_W'(batch_stride_reg);
            count_next      = '0;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;
    end

    // one product per lane, summed onto the batch base
    always_comb
    begin
        logic [gnd_pkg::PROD_W-1:0] prod;
        src_sum = s1_base_reg;
        for (int k = 0; k < LANES; k++)
        begin
            prod    = gnd_pkg::PROD_W'(s1_idx_reg[k]) * gnd_pkg::PROD_W'(stride_reg[k]);
            src_sum = src_sum + OFS_W'(prod);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg        <= gnd_pkg::DEPTH_W'(1);
            block_len_reg    <= gnd_pkg::DESC_W'(1);
            tuples_reg       <= gnd_pkg::COUNT_W'(1);
            batch_stride_reg <= '0;
            for (int k = 0; k < LANES; k++)
            begin
                stride_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gnd_pkg::REG_INDEX_DEPTH:
                begin
                    depth_reg <= cfg_data[gnd_pkg::DEPTH_W-1:0];
                end
                gnd_pkg::REG_BLOCK_LEN:
                begin
                    block_len_reg <= cfg_data;
                end
                gnd_pkg::REG_TUPLES_PER_BATCH:
                begin
                    tuples_reg <= cfg_data[gnd_pkg::COUNT_W-1:0];
                end
                gnd_pkg::REG_BATCH_STRIDE:
                begin
                    batch_stride_reg <= cfg_data;
                end
                default:
                begin
                    // strides of lanes beyond the built ones are dropped
                    for (int k = 0; k < LANES; k++)
                    begin
                        if (cfg_index == gnd_pkg::stride_index(k))
                        begin
                            stride_reg[k] <= cfg_data;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_base_reg <= '0;
            dst_reg        <= '0;
            count_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                batch_base_reg <= batch_base_next;
                dst_reg        <= dst_next;
                count_reg      <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                s1_idx_reg[k] <= (k < int'(used_depth)) ? idx_vec[k] : '0;
            end
            s1_base_reg <= batch_base_reg;
            s1_dst_reg  <= dst_reg;
            s1_last_reg <= last;
        end
        if (out_adv && s1_valid_reg)
        begin
            out_src_reg  <= gnd_pkg::DESC_W'(src_sum);
            out_dst_reg  <= gnd_pkg::DESC_W'(s1_dst_reg);
            out_last_reg <= s1_last_reg;
        end
    end

    assign desc_out.valid      = out_valid_reg;
    assign desc_out.src_offset = out_src_reg;
    assign desc_out.dst_offset = out_dst_reg;
    assign desc_out.batch_end  = out_last_reg;

endmodule

// ===== sv/gnd_checker.sv =====
// ----------------------------------------------------------------------------
// gnd_checker
// Port-level checks of the gather-nd address generator, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gnd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [gnd_pkg::DESC_W-1:0] src_offset,
    input logic [gnd_pkg::DESC_W-1:0] dst_offset,
    input logic                       batch_end
);

    logic                           in_xfer;
    logic                           out_stall;
    logic [2*gnd_pkg::DESC_W:0]     desc_bits;

    assign in_xfer   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;
    assign desc_bits = {src_offset, dst_offset, batch_end};

    `ASSERT_ALWAYS(a_no_desc_in_reset, !rst_n |-> !out_valid, "descriptor valid during reset")
    `ASSERT_CLK(a_stall_valid, out_stall |=> out_valid, "stalled descriptor dropped")
    `ASSERT_CLK(a_stall_data, out_stall |=> $stable(desc_bits), "stalled descriptor changed")
    `ASSERT_CLK(a_desc_from_tuple, $rose(out_valid) |-> $past(in_xfer, 2), "orphan descriptor")
    `ASSERT_CLK(a_ready_when_empty, !out_valid |-> in_ready, "tuple refused with empty output")

endmodule

bind gather_nd_address_generator gnd_checker u_gnd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (idx_in.valid),
    .in_ready   (idx_in.ready),
    .out_valid  (desc_out.valid),
    .out_ready  (desc_out.ready),
    .src_offset (desc_out.src_offset),
    .dst_offset (desc_out.dst_offset),
    .batch_end  (desc_out.batch_end)
);

// ===== sim/gather_nd_address_generator_tb.sv =====
// ----------------------------------------------------------------------------
// gather_nd_address_generator_tb
// Drives index tuples into the gather-nd address generator and checks every
// copy descriptor against a cycle-free model of the offset arithmetic, over
// directed corner cases, random traffic with idle and stall phases, and a
// long output hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module gather_nd_address_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_TICKS = 7;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_TICKS = 4;
    localparam int HOLD_TICKS  = 80;

    typedef logic [gnd_pkg::NUM_IDX-1:0][gnd_pkg::IDX_W-1:0] tuple_t;

    typedef struct packed {
        logic [gnd_pkg::DESC_W-1:0] src_offset;
        logic [gnd_pkg::DESC_W-1:0] dst_offset;
        logic                       batch_end;
    } desc_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [gnd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [gnd_pkg::CFG_DATA_W-1:0]  cfg_data;

    gnd_idx_if  idx_ch ();
    gnd_desc_if desc_ch ();

    gather_nd_address_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .idx_in    (idx_ch),
        .desc_out  (desc_ch)
    );

    // offset model: configuration copy
    logic [gnd_pkg::DEPTH_W-1:0]  depth_reg;
    logic [gnd_pkg::STRIDE_W-1:0] stride_reg [gnd_pkg::NUM_IDX];
    logic [gnd_pkg::DESC_W-1:0]   block_len_reg;
    logic [gnd_pkg::COUNT_W-1:0]  tpb_reg;
    logic [gnd_pkg::DESC_W-1:0]   batch_stride_reg;

    // offset model: running state
    logic [gnd_pkg::DESC_W-1:0]   cur_batch_base;
    logic [gnd_pkg::DESC_W-1:0]   cur_dst;
    logic [gnd_pkg::COUNT_W-1:0]  cur_tuple_count;

    desc_t pending_desc [$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned cycle_count;
    int unsigned hold_until;
    int unsigned error_count;
    int unsigned quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2.0) clk = ~clk;
        end
    end

    function automatic desc_t next_descriptor(input tuple_t t);
        desc_t       d;
        int unsigned lanes;
        logic [63:0] prod;
        logic [31:0] limit;
        lanes = (depth_reg > gnd_pkg::NUM_IDX) ? gnd_pkg::NUM_IDX : int'(depth_reg);
        d.src_offset = cur_batch_base;
        for (int k = 0; k < lanes; k++)
        begin
            prod = 64'(t[k]) * 64'(stride_reg[k]);
            d.src_offset = d.src_offset + prod[31:0];
        end
        // a batch size of zero acts as one, and lowering it mid-batch ends the batch
        limit = (tpb_reg == '0) ? 32'd1 : 32'(tpb_reg);
        d.batch_end = (32'(cur_tuple_count) + 32'd1) >= limit;
        d.dst_offset = cur_dst;
        cur_dst = cur_dst + block_len_reg;
        if (d.batch_end)
        begin
            cur_batch_base = cur_batch_base + batch_stride_reg;
            cur_tuple_count = '0;
        end
        else
        begin
            cur_tuple_count = cur_tuple_count + gnd_pkg::COUNT_W'(1);
        end
        return d;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic write_reg(input gnd_pkg::cfg_reg_t r,
                             input logic [gnd_pkg::CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        case (r)
            gnd_pkg::REG_INDEX_DEPTH:      depth_reg        = v[gnd_pkg::DEPTH_W-1:0];
            gnd_pkg::REG_STRIDE_0:         stride_reg[0]    = v;
            gnd_pkg::REG_STRIDE_1:         stride_reg[1]    = v;
            gnd_pkg::REG_STRIDE_2:         stride_reg[2]    = v;
            gnd_pkg::REG_STRIDE_3:         stride_reg[3]    = v;
            gnd_pkg::REG_BLOCK_LEN:        block_len_reg    = v;
            gnd_pkg::REG_TUPLES_PER_BATCH: tpb_reg          = v[gnd_pkg::COUNT_W-1:0];
            gnd_pkg::REG_BATCH_STRIDE:     batch_stride_reg = v;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_tuple(input tuple_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            idx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        idx_ch.valid <= 1'b1;
        idx_ch.idx_0 <= t[0];
        idx_ch.idx_1 <= t[1];
        idx_ch.idx_2 <= t[2];
        idx_ch.idx_3 <= t[3];
        @(posedge clk);
        while (!idx_ch.ready)
        begin
            @(posedge clk);
        end
        pending_desc.push_back(next_descriptor(t));
    endtask

    // stop offering and wait until every descriptor is back
    task automatic settle();
        idx_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_desc.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    function automatic tuple_t random_tuple();
        tuple_t t;
        for (int k = 0; k < gnd_pkg::NUM_IDX; k++)
        begin
            case ($urandom_range(9))
                0, 1:    t[k] = '0;
                2:       t[k] = '1;
                default: t[k] = gnd_pkg::IDX_W'($urandom);
            endcase
        end
        return t;
    endfunction

    function automatic logic [31:0] random_wide();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(1, 16));
            default: return $urandom;
        endcase
    endfunction

    task automatic randomize_config();
        logic [31:0] tpb;
        case ($urandom_range(5))
            0:       tpb = 32'd0;
            1:       tpb = 32'd1;
            2:       tpb = 32'hFF_FFFF;
            default: tpb = 32'($urandom_range(2, 9));
        endcase
        write_reg(gnd_pkg::REG_INDEX_DEPTH, 32'($urandom_range(0, 7)));
        write_reg(gnd_pkg::REG_STRIDE_0, random_wide());
        write_reg(gnd_pkg::REG_STRIDE_1, random_wide());
        write_reg(gnd_pkg::REG_STRIDE_2, random_wide());
        write_reg(gnd_pkg::REG_STRIDE_3, random_wide());
        write_reg(gnd_pkg::REG_BLOCK_LEN, random_wide());
        write_reg(gnd_pkg::REG_TUPLES_PER_BATCH, tpb);
        write_reg(gnd_pkg::REG_BATCH_STRIDE, random_wide());
    endtask

    task automatic test_reset_defaults();
        send_tuple('0);
        send_tuple('1);
        send_tuple({16'd4, 16'd3, 16'd2, 16'd1});
        settle();
    endtask

    task automatic test_full_depth_extremes();
        write_reg(gnd_pkg::REG_INDEX_DEPTH, 32'd4);
        write_reg(gnd_pkg::REG_STRIDE_0, 32'hFFFF_FFFF);
        write_reg(gnd_pkg::REG_STRIDE_1, 32'hFFFF_FFFF);
        write_reg(gnd_pkg::REG_STRIDE_2, 32'hFFFF_FFFF);
        write_reg(gnd_pkg::REG_STRIDE_3, 32'hFFFF_FFFF);
        write_reg(gnd_pkg::REG_BLOCK_LEN, 32'hFFFF_FFFF);
        write_reg(gnd_pkg::REG_TUPLES_PER_BATCH, 32'd3);
        write_reg(gnd_pkg::REG_BATCH_STRIDE, 32'hFFFF_FFFF);
        send_tuple('1);
        send_tuple('0);
        send_tuple({16'h8000, 16'h0001, 16'hAAAA, 16'h5555});
        send_tuple({16'h5555, 16'hAAAA, 16'h0001, 16'h8000});
        settle();
    endtask

    task automatic test_depth_cases();
        write_reg(gnd_pkg::REG_STRIDE_0, 32'h0000_0001);
        write_reg(gnd_pkg::REG_STRIDE_1, 32'h0000_0100);
        write_reg(gnd_pkg::REG_STRIDE_2, 32'h0001_0000);
        write_reg(gnd_pkg::REG_STRIDE_3, 32'h0100_0000);
        write_reg(gnd_pkg::REG_BLOCK_LEN, 32'd3);
        write_reg(gnd_pkg::REG_TUPLES_PER_BATCH, 32'd2);
        write_reg(gnd_pkg::REG_BATCH_STRIDE, 32'h10);
        // no component used at all
        write_reg(gnd_pkg::REG_INDEX_DEPTH, 32'd0);
        send_tuple('1);
        settle();
        // depths above four clamp
        write_reg(gnd_pkg::REG_INDEX_DEPTH, 32'd7);
        send_tuple({16'd4, 16'd3, 16'd2, 16'd1});
        settle();
        write_reg(gnd_pkg::REG_INDEX_DEPTH, 32'd5);
        send_tuple({16'd9, 16'd8, 16'd7, 16'd6});
        settle();
        // unused lanes carry garbage
        write_reg(gnd_pkg::REG_INDEX_DEPTH, 32'd2);
        send_tuple({16'hFFFF, 16'hFFFF, 16'd2, 16'd1});
        settle();
        write_reg(gnd_pkg::REG_INDEX_DEPTH, 32'd3);
        send_tuple({16'hFFFF, 16'd3, 16'd2, 16'd1});
        settle();
    endtask

    task automatic test_batch_edges();
        write_reg(gnd_pkg::REG_TUPLES_PER_BATCH, 32'd0);
        write_reg(gnd_pkg::REG_BATCH_STRIDE, 32'h1000);
        write_reg(gnd_pkg::REG_BLOCK_LEN, 32'd0);
        repeat (3) send_tuple(random_tuple());
        settle();
        write_reg(gnd_pkg::REG_TUPLES_PER_BATCH, 32'd5);
        write_reg(gnd_pkg::REG_BLOCK_LEN, 32'd7);
        repeat (3) send_tuple(random_tuple());
        settle();
        // batch shrinks below the running count
        write_reg(gnd_pkg::REG_TUPLES_PER_BATCH, 32'd2);
        repeat (2) send_tuple(random_tuple());
        settle();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        randomize_config();
        hold_until = cycle_count + HOLD_TICKS;
        repeat (30) send_tuple(random_tuple());
        // hold the input until the pipeline is empty
        settle();
    endtask

    task automatic run_traffic_phase(input int unsigned idle_pct,
                                     input int unsigned stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (4)
        begin
            settle();
            randomize_config();
            repeat (45) send_tuple(random_tuple());
        end
        settle();
    endtask

    // descriptor check and output ready
    always @(posedge clk)
    begin
        desc_t want;
        if (rst_n && desc_ch.valid && desc_ch.ready)
        begin
            if (pending_desc.size() == 0)
            begin
                report_mismatch("unexpected descriptor src", desc_ch.src_offset, 32'd0);
            end
            else
            begin
                want = pending_desc.pop_front();
                if (desc_ch.src_offset !== want.src_offset)
                    report_mismatch("src_offset", desc_ch.src_offset, want.src_offset);
                if (desc_ch.dst_offset !== want.dst_offset)
                    report_mismatch("dst_offset", desc_ch.dst_offset, want.dst_offset);
                if (desc_ch.batch_end !== want.batch_end)
                    report_mismatch("batch_end", 32'(desc_ch.batch_end),
                                    32'(want.batch_end));
            end
        end
        cycle_count++;
        // long hold-off counted in cycles
        if (cycle_count < hold_until)
        begin
            desc_ch.ready <= 1'b0;
        end
        else
        begin
            desc_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((idx_ch.valid && idx_ch.ready) || (desc_ch.valid && desc_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        idx_ch.valid   <= 1'b0;
        idx_ch.idx_0   <= '0;
        idx_ch.idx_1   <= '0;
        idx_ch.idx_2   <= '0;
        idx_ch.idx_3   <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_until     = 0;
        error_count    = 0;

        depth_reg        = 3'd1;
        stride_reg       = '{default: '0};
        block_len_reg    = 32'd1;
        tpb_reg          = 24'd1;
        batch_stride_reg = '0;
        cur_batch_base   = '0;
        cur_dst          = '0;
        cur_tuple_count  = '0;

        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_full_depth_extremes();
        test_depth_cases();
        test_batch_edges();
        run_traffic_phase(0, 0);
        run_traffic_phase(53, 0);
        run_traffic_phase(0, 53);
        run_traffic_phase(38, 38);
        test_backpressure();

        settle();
        repeat (16) @(posedge clk);
        if (error_count == 0 && pending_desc.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== gather_nd_address_generator.f =====
+incdir+sv
sv/gnd_pkg.sv
sv/gnd_if.sv
sv/gather_nd_address_generator.sv
sv/gnd_checker.sv
sim/gather_nd_address_generator_tb.sv
